/* src/edfq_pkg.sv */
// edfq_pkg: sizes, codes and controller/datapath command and status types
// for the EDF/FIFO wait queue. No dependencies.

package edfq_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int ID_W    = 8;
  localparam int KEY_W   = 48;
  localparam int OCC_W   = 5;
  localparam int STAT_W  = 2;
  localparam int ENTRY_W = ID_W + KEY_W;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // read address select
  localparam logic [1:0] RD_POS_PREV  = 2'd0;
  localparam logic [1:0] RD_POS_PREV2 = 2'd1;
  localparam logic [1:0] RD_HEAD_NEXT = 2'd2;

  typedef struct packed {
    logic              latch;      // capture input word, start pos at tail
    logic              pop;        // advance head, drop count
    logic              shift;      // move read entry back one place
    logic              wr_new;     // write new entry at pos, grow queue
    logic              load_head;  // head id from read data
    logic              set_status;
    logic [STAT_W-1:0] status;
    logic [1:0]        rd_sel;
    logic              load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic op;
    logic full;
    logic empty;
    logic edf_mode;
    logic walk_go;   // read entry must move back
    logic out_free;
  } dp_stat_t;

endpackage

/* src/edf_fifo_wait_queue.sv */
// edf_fifo_wait_queue: top level of the wait queue, controller plus datapath.
// Depends on edfq_pkg, edfq_ctrl, edfq_datapath.

// Wait queue of up to DEPTH (16) requesters for one shared resource. A word
// on the input channel is a push (op 0: requester_id, time_key) or a pop
// (op 1, removes the head). With edf_mode 0 pushes append in arrival order;
// with edf_mode 1 an entry goes ahead of all queued entries whose key is
// equal or larger. Each input word gives one result word: head id after the
// step (0 when empty), occupancy and status (0 done, 1 push rejected full,
// 2 pop rejected empty). One word is processed at a time. An EDF push onto a
// non-empty queue walks from the tail towards the head and moves back one
// place each queued entry whose key is equal or larger, at most DEPTH - 1
// (15 at DEPTH 16), one entry per cycle through the entry RAM's single read
// port, before it writes the new entry. The result register lets the next word
// be accepted while a result waits. cfg_ready is always high; edf_mode
// changes affect later pushes only.

module edf_fifo_wait_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        op,
  input  logic [edfq_pkg::ID_W-1:0]   requester_id,
  input  logic [edfq_pkg::KEY_W-1:0]  time_key,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [edfq_pkg::ID_W-1:0]   head_id,
  output logic [edfq_pkg::OCC_W-1:0]  occupancy,
  output logic [edfq_pkg::STAT_W-1:0] status
);

  edfq_pkg::dp_cmd_t  cmd;
  edfq_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  edfq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  edfq_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .op           (op),
    .requester_id (requester_id),
    .time_key     (time_key),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .head_id      (head_id),
    .occupancy    (occupancy),
    .status       (status),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule

/* src/edfq_ram.sv */
// edfq_ram: generic single write port, single read port RAM with a
// registered read. No dependencies.

module edfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* src/edfq_ctrl.sv */
// edfq_ctrl: controller state machine of the wait queue.
// Depends on edfq_pkg for command and status types.

module edfq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  edfq_pkg::dp_stat_t stat,
  output edfq_pkg::dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_WALK = 3'd2;
  localparam logic [2:0] S_HEAD = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.status = edfq_pkg::ST_DONE;
    cmd.rd_sel = edfq_pkg::RD_POS_PREV;
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.op == edfq_pkg::OP_POP) begin
          if (stat.empty) begin
            cmd.set_status = 1'b1;
            cmd.status     = edfq_pkg::ST_EMPTY;
            state_next     = S_DONE;
          end else begin
            cmd.pop    = 1'b1;
            cmd.rd_sel = edfq_pkg::RD_HEAD_NEXT;
            state_next = S_HEAD;
          end
        end else begin
          if (stat.full) begin
            cmd.set_status = 1'b1;
            cmd.status     = edfq_pkg::ST_FULL;
            state_next     = S_DONE;
          end else if (stat.edf_mode && !stat.empty) begin
            cmd.rd_sel = edfq_pkg::RD_POS_PREV;
            state_next = S_WALK;
          end else begin
            cmd.wr_new = 1'b1;
            state_next = S_DONE;
          end
        end
      end
      S_WALK: begin
        // read of the next entry towards the head goes out speculatively
        if (stat.walk_go) begin
          cmd.shift  = 1'b1;
          cmd.rd_sel = edfq_pkg::RD_POS_PREV2;
        end else begin
          cmd.wr_new = 1'b1;
          state_next = S_DONE;
        end
      end
      S_HEAD: begin
        cmd.load_head = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* src/edfq_datapath.sv */
// edfq_datapath: circular entry store, pointers, count, walk position,
// mode register and result register. Depends on edfq_pkg and edfq_ram.

module edfq_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic                              cfg_data,
  input  logic                              op,
  input  logic [edfq_pkg::ID_W-1:0]         requester_id,
  input  logic [edfq_pkg::KEY_W-1:0]        time_key,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [edfq_pkg::ID_W-1:0]         head_id,
  output logic [edfq_pkg::OCC_W-1:0]        occupancy,
  output logic [edfq_pkg::STAT_W-1:0]       status,
  input  edfq_pkg::dp_cmd_t                 cmd,
  output edfq_pkg::dp_stat_t                stat
);

  logic                              edf_mode;
  logic                              item_op;
  logic [edfq_pkg::ID_W-1:0]         item_id;
  logic [edfq_pkg::KEY_W-1:0]        item_key;
  logic [edfq_pkg::IDX_W-1:0]        head_ptr;
  logic [edfq_pkg::IDX_W-1:0]        tail_ptr;
  logic [edfq_pkg::IDX_W-1:0]        pos;
  logic [edfq_pkg::CNT_W-1:0]        count;
  logic [edfq_pkg::CNT_W-1:0]        remaining;
  logic [edfq_pkg::ID_W-1:0]         head_reg;
  logic [edfq_pkg::STAT_W-1:0]       res_status;

  logic [edfq_pkg::IDX_W-1:0]        pos_prev;
  logic [edfq_pkg::IDX_W-1:0]        pos_prev2;
  logic [edfq_pkg::IDX_W-1:0]        head_next;
  logic [edfq_pkg::IDX_W-1:0]        tail_next;
  logic                              wr_en;
  logic [edfq_pkg::ENTRY_W-1:0]      wr_data;
  logic [edfq_pkg::IDX_W-1:0]        rd_addr;
  logic [edfq_pkg::ENTRY_W-1:0]      rd_data;
  logic [edfq_pkg::ID_W-1:0]         rd_id;
  logic [edfq_pkg::KEY_W-1:0]        rd_key;

  function automatic logic [edfq_pkg::IDX_W-1:0] ptr_inc(
    input logic [edfq_pkg::IDX_W-1:0] p
  );
    if (p == edfq_pkg::IDX_W'(edfq_pkg::DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  function automatic logic [edfq_pkg::IDX_W-1:0] ptr_dec(
    input logic [edfq_pkg::IDX_W-1:0] p
  );
    if (p == '0) begin
      return edfq_pkg::IDX_W'(edfq_pkg::DEPTH - 1);
    end
    return p - 1'b1;
  endfunction

  assign pos_prev  = ptr_dec(pos);
  assign pos_prev2 = ptr_dec(pos_prev);
  assign head_next = ptr_inc(head_ptr);
  assign tail_next = ptr_inc(tail_ptr);

  assign rd_id  = rd_data[edfq_pkg::ENTRY_W-1 -: edfq_pkg::ID_W];
  assign rd_key = rd_data[edfq_pkg::KEY_W-1:0];

  always_comb begin
    unique case (cmd.rd_sel)
      edfq_pkg::RD_POS_PREV:  rd_addr = pos_prev;
      edfq_pkg::RD_POS_PREV2: rd_addr = pos_prev2;
      edfq_pkg::RD_HEAD_NEXT: rd_addr = head_next;
      default:                rd_addr = pos_prev;
    endcase
  end

  assign wr_en   = cmd.shift | cmd.wr_new;
  assign wr_data = cmd.shift ? rd_data : {item_id, item_key};

  edfq_ram #(
    .WIDTH (edfq_pkg::ENTRY_W),
    .DEPTH (edfq_pkg::DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pos),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      edf_mode  <= 1'b0;
      head_ptr  <= '0;
      tail_ptr  <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        edf_mode <= cfg_data;
      end
      if (cmd.pop) begin
        head_ptr <= head_next;
        count    <= count - 1'b1;
      end
      if (cmd.wr_new) begin
        tail_ptr <= tail_next;
        count    <= count + 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_op    <= op;
      item_id    <= requester_id;
      item_key   <= time_key;
      pos        <= tail_ptr;
      remaining  <= count;
      res_status <= edfq_pkg::ST_DONE;
    end
    if (cmd.set_status) begin
      res_status <= cmd.status;
    end
    if (cmd.shift) begin
      pos       <= pos_prev;
      remaining <= remaining - 1'b1;
    end
    // new entry lands at the head when nothing is left ahead of it
    if (cmd.wr_new && remaining == '0) begin
      head_reg <= item_id;
    end
    if (cmd.load_head) begin
      head_reg <= rd_id;
    end
    if (cmd.load_out) begin
      head_id   <= (count != '0) ? head_reg : '0;
      occupancy <= edfq_pkg::OCC_W'(count);
      status    <= res_status;
    end
  end

  assign stat.op       = item_op;
  assign stat.full     = (count == edfq_pkg::CNT_W'(edfq_pkg::DEPTH));
  assign stat.empty    = (count == '0);
  assign stat.edf_mode = edf_mode;
  assign stat.walk_go  = (remaining != '0) && (rd_key >= item_key);
  assign stat.out_free = !out_valid || out_ready;

endmodule

/* src/edfq_checker.sv */
// edfq_checker: port-level assertions for the wait queue, bound to the top.
// Depends on edfq_pkg and edf_fifo_wait_queue.

module edfq_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [edfq_pkg::ID_W-1:0]   head_id,
  input logic [edfq_pkg::OCC_W-1:0]  occupancy,
  input logic [edfq_pkg::STAT_W-1:0] status
);

  // status code 3 is never produced
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == edfq_pkg::ST_DONE || status == edfq_pkg::ST_FULL ||
                   status == edfq_pkg::ST_EMPTY))
    else $error("edfq: bad status code");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == edfq_pkg::ST_FULL)
      |-> occupancy == edfq_pkg::OCC_W'(edfq_pkg::DEPTH))
    else $error("edfq: full reject with queue not full");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == edfq_pkg::ST_EMPTY) |-> (occupancy == '0 && head_id == '0))
    else $error("edfq: empty reject with entries held");

  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    (out_valid && occupancy == '0) |-> head_id == '0)
    else $error("edfq: head id on empty queue");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(head_id) &&
                                   $stable(occupancy) && $stable(status)))
    else $error("edfq: stalled result word changed");

endmodule

bind edf_fifo_wait_queue edfq_checker u_edfq_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .head_id   (head_id),
  .occupancy (occupancy),
  .status    (status)
);

/* tb/sv/tb.sv */
// tb: self-checking bench for edf_fifo_wait_queue, with its own queue predictor,
// a negedge driver fed from a word queue and a posedge monitor.
// Depends on edfq_pkg and the edf_fifo_wait_queue RTL.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic                       op;
    logic [edfq_pkg::ID_W-1:0]  id;
    logic [edfq_pkg::KEY_W-1:0] key;
  } word_t;

  typedef struct packed {
    logic [edfq_pkg::ID_W-1:0]   head;
    logic [edfq_pkg::OCC_W-1:0]  occ;
    logic [edfq_pkg::STAT_W-1:0] stat;
  } wq_result_t;

  logic                          clk          = 1'b0;
  logic                          rst          = 1'b1;
  logic                          cfg_valid    = 1'b0;
  logic                          cfg_ready;
  logic                          cfg_data     = 1'b0;
  logic                          in_valid     = 1'b0;
  logic                          in_ready;
  logic                          op           = edfq_pkg::OP_PUSH;
  logic [edfq_pkg::ID_W-1:0]     requester_id = '0;
  logic [edfq_pkg::KEY_W-1:0]    time_key     = '0;
  logic                          out_valid;
  logic                          out_ready    = 1'b0;
  logic [edfq_pkg::ID_W-1:0]     head_id;
  logic [edfq_pkg::OCC_W-1:0]    occupancy;
  logic [edfq_pkg::STAT_W-1:0]   status;

  edf_fifo_wait_queue uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .requester_id (requester_id),
    .time_key     (time_key),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .head_id      (head_id),
    .occupancy    (occupancy),
    .status       (status)
  );

  // predictor state
  logic [edfq_pkg::ID_W-1:0]  slot_id  [edfq_pkg::DEPTH];
  logic [edfq_pkg::KEY_W-1:0] slot_key [edfq_pkg::DEPTH];
  int unsigned                held;
  logic                       sort_by_key;

  word_t      word_queue[$];
  wq_result_t due_results[$];

  int  send_idle_pct = 15;
  int  recv_idle_pct = 60;
  int  fault_count   = 0;
  int  idle_run      = 0;
  logic in_took      = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic wq_result_t apply_word(logic w_op, logic [edfq_pkg::ID_W-1:0] w_id,
                                            logic [edfq_pkg::KEY_W-1:0] w_key);
    wq_result_t r;
    int pos;
    r.stat = edfq_pkg::ST_DONE;
    if (w_op == edfq_pkg::OP_PUSH) begin
      if (held >= edfq_pkg::DEPTH) begin
        r.stat = edfq_pkg::ST_FULL;
      end else begin
        pos = held;
        // new entry goes ahead of every entry with an equal or larger key
        if (sort_by_key) begin
          while (pos > 0 && slot_key[pos-1] >= w_key) begin
            slot_id[pos]  = slot_id[pos-1];
            slot_key[pos] = slot_key[pos-1];
            pos--;
          end
        end
        slot_id[pos]  = w_id;
        slot_key[pos] = w_key;
        held++;
      end
    end else begin
      if (held == 0) begin
        r.stat = edfq_pkg::ST_EMPTY;
      end else begin
        for (int i = 0; i + 1 < held; i++) begin
          slot_id[i]  = slot_id[i+1];
          slot_key[i] = slot_key[i+1];
        end
        held--;
      end
    end
    r.head = (held > 0) ? slot_id[0] : '0;
    r.occ  = held[edfq_pkg::OCC_W-1:0];
    return r;
  endfunction

  // driver: payload changes on the falling edge only
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (!in_valid || in_took) begin
        if (word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          op           <= word_queue[0].op;
          requester_id <= word_queue[0].id;
          time_key     <= word_queue[0].key;
          in_valid     <= 1'b1;
          word_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: results are checked before the word taken at this edge is predicted
  always @(posedge clk) begin
    wq_result_t want;
    wq_result_t got;
    if (rst) begin
      held        = 0;
      sort_by_key = 1'b0;
      due_results.delete();
      in_took    <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.head = head_id;
        got.occ  = occupancy;
        got.stat = status;
        if (due_results.size() == 0) begin
          fault_count++;
          if (fault_count <= REPORT_MAX)
            $display("unexpected result word: head %0d occ %0d status %0d",
                     got.head, got.occ, got.stat);
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            fault_count++;
            if (fault_count <= REPORT_MAX)
              $display("mismatch: want head %0d occ %0d st %0d, got head %0d occ %0d st %0d",
                       want.head, want.occ, want.stat, got.head, got.occ, got.stat);
          end
        end
      end
      if (in_valid && in_ready)
        due_results.push_back(apply_word(op, requester_id, time_key));
      if (cfg_valid && cfg_ready)
        sort_by_key = cfg_data;
      in_took <= in_valid && in_ready;
    end
  end

  // watchdog: only counts while some word is still outstanding
  always @(posedge clk) begin
    if (!rst && (in_valid || cfg_valid || word_queue.size() != 0 ||
                 due_results.size() != 0) &&
        !(in_valid && in_ready) && !(out_valid && out_ready) &&
        !(cfg_valid && cfg_ready))
      idle_run++;
    else
      idle_run = 0;
    if (idle_run >= STALL_LIMIT) begin
      $display("[edf_fifo_wait_queue] ERROR");
      $finish;
    end
  end

  task automatic add_word(logic w_op, logic [edfq_pkg::ID_W-1:0] w_id,
                          logic [edfq_pkg::KEY_W-1:0] w_key);
    word_t w;
    w.op  = w_op;
    w.id  = w_id;
    w.key = w_key;
    word_queue.push_back(w);
  endtask

  task automatic wait_quiet();
    while (word_queue.size() != 0 || in_valid || due_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    @(negedge clk);
    cfg_data  <= m;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // runs of pushes and pops with a drifting push bias so the queue
  // swings between empty and full; some runs use narrow keys for ties
  task automatic queue_random(int count);
    int push_pct;
    int key_style;
    int left;
    logic [63:0] raw;
    logic [edfq_pkg::KEY_W-1:0] last_key;
    logic [edfq_pkg::KEY_W-1:0] k;
    left     = 0;
    push_pct = 50;
    key_style = 1;
    last_key = '0;
    for (int i = 0; i < count; i++) begin
      if (left == 0) begin
        left = $urandom_range(8, 40);
        case ($urandom_range(0, 2))
          0:       push_pct = 25;
          1:       push_pct = 55;
          default: push_pct = 85;
        endcase
        key_style = $urandom_range(0, 3);
      end
      left--;
      raw = {$urandom, $urandom};
      case (key_style)
        0:       k = edfq_pkg::KEY_W'(raw[2:0]);
        1:       k = raw[edfq_pkg::KEY_W-1:0];
        2:       k = {edfq_pkg::KEY_W{1'b1}} - edfq_pkg::KEY_W'(raw[1:0]);
        default: k = raw[50] ? last_key : raw[edfq_pkg::KEY_W-1:0];
      endcase
      last_key = k;
      add_word(($urandom_range(99) < push_pct) ? edfq_pkg::OP_PUSH : edfq_pkg::OP_POP,
               edfq_pkg::ID_W'($urandom_range(1, 255)), k);
    end
  endtask

  initial begin
    logic [63:0] raw;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // arrival order: pop on empty, fill to the brim with extreme ids and keys,
    // then one push too many
    add_word(edfq_pkg::OP_POP, 8'd1, '0);
    add_word(edfq_pkg::OP_PUSH, 8'd0, '0);
    add_word(edfq_pkg::OP_PUSH, 8'hFF, {edfq_pkg::KEY_W{1'b1}});
    add_word(edfq_pkg::OP_PUSH, 8'h55, {(edfq_pkg::KEY_W/2){2'b10}});
    add_word(edfq_pkg::OP_PUSH, 8'hAA, {(edfq_pkg::KEY_W/2){2'b01}});
    for (int i = 4; i < edfq_pkg::DEPTH; i++) begin
      raw = {$urandom, $urandom};
      add_word(edfq_pkg::OP_PUSH, edfq_pkg::ID_W'(i * 13 + 1),
               raw[edfq_pkg::KEY_W-1:0]);
    end
    add_word(edfq_pkg::OP_PUSH, 8'h7F, 48'd1);
    wait_quiet();

    // switch to key order with entries still queued
    write_mode(1'b1);
    add_word(edfq_pkg::OP_POP, 8'd0, '0);
    add_word(edfq_pkg::OP_POP, 8'd0, '0);
    add_word(edfq_pkg::OP_PUSH, 8'd9, '0);
    add_word(edfq_pkg::OP_PUSH, 8'd10, {edfq_pkg::KEY_W{1'b1}});
    add_word(edfq_pkg::OP_POP, 8'd0, '0);
    add_word(edfq_pkg::OP_PUSH, 8'd0, 48'd5);
    wait_quiet();

    for (int p = 0; p < 6; p++) begin
      if (p < 2) begin
        send_idle_pct = 15;
        recv_idle_pct = 60;
      end else if (p < 4) begin
        send_idle_pct = 60;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_mode(logic'(p % 2) ^ logic'(p >= 4));
      queue_random(235);
      wait_quiet();
    end

    repeat (40) @(posedge clk);
    if (fault_count == 0 && due_results.size() == 0)
      $display("[edf_fifo_wait_queue] OK");
    else
      $display("[edf_fifo_wait_queue] ERROR");
    $finish;
  end

endmodule
